// ===== rtl/pum_pkg.sv =====
// Shared types, codes and constants of the page usage map.
package pum_pkg;

	localparam int ID_W        = 31;
	localparam int ENTRIES_DEF = 8192;
	localparam int WORD_W      = 16;
	localparam int BIT_W       = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}};

	localparam logic [2:0] OP_SET    = 3'd0;
	localparam logic [2:0] OP_QUERY  = 3'd1;
	localparam logic [2:0] OP_EXTEND = 3'd2;
	localparam logic [2:0] OP_FIND   = 3'd3;
	localparam logic [2:0] OP_OWNER  = 3'd4;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_RANGE  = 2'd1;
	localparam logic [1:0] STAT_EXTEND = 2'd2;
	localparam logic [1:0] STAT_BADID  = 2'd3;

	typedef enum logic [2:0] {
		CL_SET,
		CL_QUERY,
		CL_EXTEND,
		CL_FIND,
		CL_OWNER,
		CL_BAD
	} cls_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_DIV
	} st_t;

	// one classified transaction as it waits in the queue
	typedef struct packed {
		cls_t               cls;
		logic [ID_W-1:0]    pid;
		logic signed [31:0] offset;
		logic               new_flag;
		logic [ID_W-1:0]    base;
		logic [ID_W-1:0]    lim;
	} item_t;

endpackage

// ===== rtl/pum_front.sv =====
// Front end: base page register, input acceptance and operation classification.
module pum_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [pum_pkg::ID_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               operation,
	input  logic [pum_pkg::ID_W-1:0] page_id,
	input  logic                     new_flag,
	input  logic                     clearing,
	output logic                     push_valid,
	input  logic                     push_ready,
	output pum_pkg::item_t           push_item
);

	logic [pum_pkg::ID_W-1:0] base_page_q;
	pum_pkg::cls_t            cls;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_page_q <= pum_pkg::ID_W'(1);
		end else if (cfg_valid) begin
			base_page_q <= cfg_data;
		end
	end

	always_comb begin
		unique case (operation)
			pum_pkg::OP_SET:    cls = pum_pkg::CL_SET;
			pum_pkg::OP_QUERY:  cls = pum_pkg::CL_QUERY;
			pum_pkg::OP_EXTEND: cls = pum_pkg::CL_EXTEND;
			pum_pkg::OP_FIND:   cls = pum_pkg::CL_FIND;
			pum_pkg::OP_OWNER:  cls = pum_pkg::CL_OWNER;
			default:            cls = pum_pkg::CL_BAD;
		endcase
	end

	// hold off new transactions while the flag store is being wiped
	assign in_ready   = push_ready && !clearing;
	assign push_valid = in_valid && !clearing;

	always_comb begin
		push_item.cls      = cls;
		push_item.pid      = page_id;
		push_item.offset   = $signed({1'b0, page_id}) - $signed({1'b0, base_page_q});
		push_item.new_flag = new_flag;
		push_item.base     = base_page_q;
		// pages past this offset would overflow the id space
		push_item.lim      = pum_pkg::ID_MASK - base_page_q;
	end

endmodule

// ===== rtl/pum_fifo.sv =====
// Two-entry queue between the front end and the execution back end.
module pum_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pum_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pum_pkg::item_t pop_item
);

	localparam int CW = $clog2(pum_pkg::QUEUE_DEPTH + 1);

	pum_pkg::item_t              slot_q [pum_pkg::QUEUE_DEPTH];
	logic [pum_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [pum_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [CW-1:0]               count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = count_q != CW'(pum_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/pum_back.sv =====
// Back end: flag memory, tracked count, first-fit scan, owner divider, result register.
module pum_back #(
	parameter int ENTRIES = pum_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     clearing,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	input  pum_pkg::item_t           pop_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic                     flag_out,
	output logic [pum_pkg::ID_W-1:0] result_page
);

	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int LW        = CNT_W + 1;
	localparam int NWORDS    = (ENTRIES + pum_pkg::WORD_W - 1) / pum_pkg::WORD_W;
	localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int GROUP     = ENTRIES + 1;
	localparam int RW        = $clog2(GROUP);
	localparam int SW        = 2;
	localparam int DIV_STEPS = 3;
	localparam int IW        = pum_pkg::ID_W;
	localparam logic [IW-1:0] RECIP = IW'((64'd1 << IW) / GROUP);

	pum_pkg::st_t state_q, state_d;

	logic [pum_pkg::WORD_W-1:0] mem [NWORDS];
	logic [pum_pkg::WORD_W-1:0] mem_rd_q;

	logic [CNT_W-1:0]  tracked_q;
	logic [AW:0]       clr_q;
	pum_pkg::item_t    cur_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  eff_q;
	logic [AW:0]       eval_q;
	logic [IW-1:0]     qest_q;
	logic [RW:0]       rem_q;
	logic [IW-1:0]     x_q;
	logic [SW-1:0]     step_q;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              flag_q;
	logic [IW-1:0]     result_q;

	// pop decode
	logic               out_free;
	logic               pop;
	logic signed [31:0] trk_s;
	logic               in_rng;
	logic               ext_ok;
	logic [CNT_W-1:0]   pop_idx;
	logic [CNT_W-1:0]   pop_eff;

	// scan datapath
	logic [LW-1:0]              scan_base;
	logic [LW-1:0]              scan_left;
	logic [pum_pkg::WORD_W-1:0] scan_hits;
	logic                       scan_hit;
	logic [pum_pkg::BIT_W-1:0]  scan_pos;
	logic                       scan_last;
	logic [AW:0]                scan_next;
	logic [31:0]                scan_page;

	// divider datapath
	logic [2*IW-1:0] div_prod;
	logic [IW-1:0]   div_back;
	logic [IW-1:0]   div_diff;
	logic [RW-1:0]   div_rem;

	// memory and result controls
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [pum_pkg::WORD_W-1:0] wr_data;
	logic                       res_load;
	logic [1:0]                 res_status;
	logic                       res_flag;
	logic [IW-1:0]              res_page;

	assign clearing    = state_q == pum_pkg::ST_CLEAR;
	assign out_free    = !out_valid_q || out_ready;
	assign pop_ready   = (state_q == pum_pkg::ST_IDLE) && out_free;
	assign pop         = pop_valid && pop_ready;

	assign trk_s   = $signed({{(32-CNT_W){1'b0}}, tracked_q});
	assign in_rng  = (pop_item.offset > 0) && (pop_item.offset <= trk_s);
	assign ext_ok  = (pop_item.offset > trk_s) && (pop_item.offset <= 32'(ENTRIES));
	assign pop_idx = CNT_W'(pop_item.offset - 32'sd1);
	assign pop_eff = ({{(IW-CNT_W){1'b0}}, tracked_q} < pop_item.lim) ?
		tracked_q : CNT_W'(pop_item.lim);

	// first-fit word evaluation: mem_rd_q holds word eval_q
	always_comb begin
		scan_base = LW'({eval_q, {pum_pkg::BIT_W{1'b0}}});
		scan_left = LW'(eff_q) - scan_base;
		for (int j = 0; j < pum_pkg::WORD_W; j++) begin
			scan_hits[j] = mem_rd_q[j] && (LW'(j) < scan_left);
		end
		scan_hit = |scan_hits;
		scan_pos = '0;
		for (int j = pum_pkg::WORD_W - 1; j >= 0; j--) begin
			if (scan_hits[j]) begin
				scan_pos = pum_pkg::BIT_W'(j);
			end
		end
		scan_last = scan_left <= LW'(pum_pkg::WORD_W);
		scan_next = eval_q + 1'b1;
		scan_page = 32'(cur_q.base) + 32'(scan_base) + 32'(scan_pos) + 32'd1;
	end

	// (page_id - 1) mod GROUP by reciprocal multiply; the quotient estimate is
	// at most one low, so one compare and subtract finishes the remainder
	always_comb begin
		div_prod = (2*IW)'(x_q) * (2*IW)'(RECIP);
		div_back = qest_q * IW'(GROUP);
		div_diff = x_q - div_back;
		div_rem  = (rem_q >= (RW+1)'(GROUP)) ? RW'(rem_q - (RW+1)'(GROUP)) : rem_q[RW-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pum_pkg::ST_CLEAR: begin
				if (clr_q == (AW+1)'(NWORDS - 1)) begin
					state_d = pum_pkg::ST_IDLE;
				end
			end
			pum_pkg::ST_IDLE: begin
				if (pop) begin
					case (pop_item.cls)
						pum_pkg::CL_SET, pum_pkg::CL_QUERY: begin
							if (in_rng) begin
								state_d = pum_pkg::ST_RMW;
							end
						end
						pum_pkg::CL_FIND: begin
							if (pop_eff != '0) begin
								state_d = pum_pkg::ST_SCAN;
							end
						end
						pum_pkg::CL_OWNER: begin
							if (pop_item.pid != '0) begin
								state_d = pum_pkg::ST_DIV;
							end
						end
						default: state_d = pum_pkg::ST_IDLE;
					endcase
				end
			end
			pum_pkg::ST_RMW: state_d = pum_pkg::ST_IDLE;
			pum_pkg::ST_SCAN: begin
				if (scan_hit || scan_last) begin
					state_d = pum_pkg::ST_IDLE;
				end
			end
			pum_pkg::ST_DIV: begin
				if (step_q == SW'(DIV_STEPS - 1)) begin
					state_d = pum_pkg::ST_IDLE;
				end
			end
			default: state_d = pum_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = AW'(idx_q >> pum_pkg::BIT_W);
		wr_data    = mem_rd_q;
		res_load   = 1'b0;
		res_status = pum_pkg::STAT_OK;
		res_flag   = 1'b0;
		res_page   = '0;
		unique case (state_q)
			pum_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q[AW-1:0];
				wr_data = '0;
			end
			pum_pkg::ST_IDLE: begin
				rd_addr = AW'(pop_idx >> pum_pkg::BIT_W);
				if (pop) begin
					case (pop_item.cls)
						pum_pkg::CL_SET, pum_pkg::CL_QUERY: begin
							if (!in_rng) begin
								res_load   = 1'b1;
								res_status = pum_pkg::STAT_RANGE;
							end
						end
						pum_pkg::CL_EXTEND: begin
							res_load   = 1'b1;
							res_status = ext_ok ? pum_pkg::STAT_OK : pum_pkg::STAT_EXTEND;
						end
						pum_pkg::CL_FIND: begin
							rd_addr = '0;
							if (pop_eff == '0) begin
								res_load = 1'b1;
							end
						end
						pum_pkg::CL_OWNER: begin
							if (pop_item.pid == '0) begin
								res_load   = 1'b1;
								res_status = pum_pkg::STAT_BADID;
							end
						end
						default: begin
							res_load   = 1'b1;
							res_status = pum_pkg::STAT_BADID;
						end
					endcase
				end
			end
			pum_pkg::ST_RMW: begin
				res_load = 1'b1;
				if (cur_q.cls == pum_pkg::CL_SET) begin
					wr_en = 1'b1;
					wr_data[idx_q[pum_pkg::BIT_W-1:0]] = cur_q.new_flag;
				end else begin
					res_flag = mem_rd_q[idx_q[pum_pkg::BIT_W-1:0]];
				end
			end
			pum_pkg::ST_SCAN: begin
				// keep the read address inside the array past the last word
				rd_addr = (scan_next < (AW+1)'(NWORDS)) ? scan_next[AW-1:0] : '0;
				if (scan_hit) begin
					res_load = 1'b1;
					res_page = scan_page[IW-1:0];
				end else if (scan_last) begin
					res_load = 1'b1;
				end
			end
			pum_pkg::ST_DIV: begin
				if (step_q == SW'(DIV_STEPS - 1)) begin
					res_load = 1'b1;
					if (div_rem == '0) begin
						res_status = pum_pkg::STAT_BADID;
					end else begin
						res_page = cur_q.pid - IW'(div_rem);
					end
				end
			end
			default: res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pum_pkg::ST_CLEAR;
			clr_q       <= '0;
			tracked_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pum_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop && pop_item.cls == pum_pkg::CL_EXTEND && ext_ok) begin
				tracked_q <= CNT_W'(pop_item.offset);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= pop_item;
			idx_q  <= pop_idx;
			eff_q  <= pop_eff;
			eval_q <= '0;
			rem_q  <= '0;
			x_q    <= pop_item.pid - IW'(1);
			step_q <= '0;
		end else begin
			if (state_q == pum_pkg::ST_SCAN) begin
				eval_q <= scan_next;
			end
			if (state_q == pum_pkg::ST_DIV) begin
				if (step_q == SW'(0)) begin
					qest_q <= div_prod[2*IW-1:IW];
				end
				if (step_q == SW'(1)) begin
					rem_q <= div_diff[RW:0];
				end
				step_q <= step_q + 1'b1;
			end
		end
		if (res_load) begin
			status_q <= res_status;
			flag_q   <= res_flag;
			result_q <= res_page;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign flag_out    = flag_q;
	assign result_page = result_q;

endmodule

// ===== rtl/page_usage_map_unit.sv =====
// Top level of the page usage map: front end, queue and back end.
//
// Channels: cfg (cfg_valid/cfg_ready/cfg_data) writes base_page and is always ready;
// the user must write it only while no transaction is in flight, which the block
// does not enforce. in carries one transaction (operation, page_id, new_flag); out
// returns exactly one result (status, flag_out, result_page) per input transaction,
// in order. The front end classifies a transaction in its accept cycle and places
// it in a two-entry queue; the back end executes one transaction at a time:
//   extend, unknown code, out-of-range set/query, page 0 owner: resolved on pop
//   set and query: registered flag word read, then write or report
//   owner lookup: reciprocal multiply, remainder, final correction
//   find first: scans 16-flag words in order until a hit or the last word
// The result is loaded into an output register as execution ends.
// A stalled receiver holds the result; the back end waits and up to two more
// transactions queue up before in_ready drops.
// Reset clears the tracked count and sets base_page to 1, then a clearing
// pass wipes the ceil(ENTRIES/16) words of flag memory (512 by default),
// during which in_ready stays low.
module page_usage_map_unit #(
	parameter int ENTRIES = pum_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [pum_pkg::ID_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               operation,
	input  logic [pum_pkg::ID_W-1:0] page_id,
	input  logic                     new_flag,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic                     flag_out,
	output logic [pum_pkg::ID_W-1:0] result_page
);

	logic           clearing;
	logic           push_valid;
	logic           push_ready;
	pum_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	pum_pkg::item_t pop_item;

	pum_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.page_id    (page_id),
		.new_flag   (new_flag),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pum_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	pum_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clearing    (clearing),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.flag_out    (flag_out),
		.result_page (result_page)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the page usage map: random and directed map operations.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              MAP_ENTRIES   = pum_pkg::ENTRIES_DEF;
	localparam longint unsigned GROUP         = MAP_ENTRIES + 1;
	localparam longint unsigned ID_MAX        = pum_pkg::ID_MASK;
	localparam longint unsigned LAST_GROUP    = ID_MAX / GROUP;
	localparam int              SETTLE_CYCLES = MAP_ENTRIES / pum_pkg::WORD_W + 64;
	localparam longint          CYCLE_LIMIT   = 4_000_000;
	localparam int              REPORT_MAX    = 10;

	// codes the block does not define
	localparam logic [2:0] OP_FIRST_RSVD = 3'd5;
	localparam logic [2:0] OP_LAST_RSVD  = 3'd7;

	typedef struct packed {
		logic [2:0]               op;
		logic [pum_pkg::ID_W-1:0] pid;
		logic                     nf;
	} page_req_t;

	typedef struct packed {
		logic [2:0]               op;
		logic [1:0]               status;
		logic                     flag;
		logic [pum_pkg::ID_W-1:0] page;
	} page_resp_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [pum_pkg::ID_W-1:0] cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic [2:0]               operation   = pum_pkg::OP_FIND;
	logic [pum_pkg::ID_W-1:0] page_id     = '0;
	logic                     new_flag    = 1'b0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic [1:0]               status;
	logic                     flag_out;
	logic [pum_pkg::ID_W-1:0] result_page;

	// map state as the block should hold it
	bit              avail_map [MAP_ENTRIES];
	longint unsigned tracked_pages = 0;
	longint unsigned base_page_m   = 1;

	page_req_t  pending_reqs [$];
	page_resp_t results_due  [$];
	page_req_t  cur_req;
	page_resp_t due_head;

	longint unsigned gen_tc        = 0;
	int              sender_idle_pct   = 7;
	int              receiver_idle_pct = 67;
	int              reqs_pushed   = 0;
	int              results_seen  = 0;
	int              fail_cnt      = 0;
	int              base_settings = 0;
	int              finds_hit     = 0;
	int              extends_taken = 0;
	longint          cycle_cnt     = 0;

	page_usage_map_unit #(.ENTRIES(MAP_ENTRIES)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.page_id    (page_id),
		.new_flag   (new_flag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.flag_out   (flag_out),
		.result_page(result_page)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				reqs_pushed - results_seen);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic bit roll_idle(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// execute one operation on the map and return what the block must answer
	function automatic page_resp_t apply_page_op(input page_req_t req);
		longint unsigned b, pid, idx, pg;
		page_resp_t r;
		b = base_page_m;
		pid = req.pid;
		r = '0;
		r.op = req.op;
		r.status = pum_pkg::STAT_OK;
		case (req.op)
			pum_pkg::OP_SET: begin
				if (pid > b && pid - b <= tracked_pages)
					avail_map[pid - b - 1] = req.nf;
				else
					r.status = pum_pkg::STAT_RANGE;
			end
			pum_pkg::OP_QUERY: begin
				if (pid > b && pid - b <= tracked_pages)
					r.flag = avail_map[pid - b - 1];
				else
					r.status = pum_pkg::STAT_RANGE;
			end
			pum_pkg::OP_EXTEND: begin
				if (pid > b + tracked_pages && pid <= b + MAP_ENTRIES) begin
					tracked_pages = pid - b;
					extends_taken++;
				end else begin
					r.status = pum_pkg::STAT_EXTEND;
				end
			end
			pum_pkg::OP_FIND: begin
				// pages past the 31-bit id space cannot be reported
				for (idx = 0; idx < tracked_pages; idx++) begin
					pg = b + idx + 1;
					if (pg > ID_MAX)
						break;
					if (avail_map[idx]) begin
						r.page = pg[pum_pkg::ID_W-1:0];
						finds_hit++;
						break;
					end
				end
			end
			pum_pkg::OP_OWNER: begin
				if (pid == 0 || pid % GROUP == 1)
					r.status = pum_pkg::STAT_BADID;
				else
					r.page = pum_pkg::ID_W'(((pid - 1) / GROUP) * GROUP + 1);
			end
			default: r.status = pum_pkg::STAT_BADID;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				results_due.push_back(apply_page_op(cur_req));
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && !roll_idle(sender_idle_pct)) begin
					cur_req = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					operation <= cur_req.op;
					page_id   <= cur_req.pid;
					new_flag  <= cur_req.nf;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("result with nothing outstanding: status %0d flag %0d page %0d",
							status, flag_out, result_page);
				end else begin
					due_head = results_due.pop_front();
					if (status != due_head.status || flag_out != due_head.flag ||
							result_page != due_head.page) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX)
							$display("op %0d: status %0d/%0d flag %0d/%0d page %0d/%0d (exp/act)",
								due_head.op, due_head.status, status, due_head.flag, flag_out,
								due_head.page, result_page);
					end
				end
			end
			out_ready <= !roll_idle(receiver_idle_pct);
		end
	end

	task automatic push_req(input logic [2:0] op, input longint unsigned pid, input logic nf);
		page_req_t req;
		longint unsigned b;
		b = base_page_m;
		req.op  = op;
		req.pid = pid[pum_pkg::ID_W-1:0];
		req.nf  = nf;
		// follow the tracked count so that later items aim at the live range
		if (op == pum_pkg::OP_EXTEND && req.pid > b + gen_tc && req.pid <= b + MAP_ENTRIES)
			gen_tc = req.pid - b;
		pending_reqs.push_back(req);
		reqs_pushed++;
	endtask

	task automatic write_base(input longint unsigned v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v[pum_pkg::ID_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_page_m = v[pum_pkg::ID_W-1:0];
		base_settings++;
	endtask

	task automatic drain();
		while (results_seen < reqs_pushed)
			@(posedge clk);
	endtask

	function automatic longint unsigned pick_tracked(input longint unsigned b,
			input longint unsigned tc);
		int unsigned sel;
		sel = $urandom_range(99);
		if (tc == 0)
			return b + $urandom_range(2);
		if (sel < 70)
			return b + $urandom_range(1, 32'(tc));
		if (sel < 80)
			return b + 1;
		if (sel < 90)
			return b + tc;
		if (sel < 95)
			return b + tc + 1;
		return b;
	endfunction

	task automatic add_random_req(input bit full_ok, input int avail_pct);
		int unsigned roll, sub;
		longint unsigned b, tc, pid;
		logic [2:0] op;
		logic nf;
		b = base_page_m;
		tc = gen_tc;
		roll = $urandom_range(99);
		sub = $urandom_range(99);
		nf = ($urandom_range(99) < avail_pct);
		pid = longint'($urandom()) & ID_MAX;
		if (roll < 30) begin
			op = pum_pkg::OP_SET;
			pid = pick_tracked(b, tc);
		end else if (roll < 55) begin
			op = pum_pkg::OP_QUERY;
			pid = pick_tracked(b, tc);
		end else if (roll < 67) begin
			op = pum_pkg::OP_EXTEND;
			if (sub < 80)
				pid = b + tc + $urandom_range(1, 24);
			else if (sub < 88)
				pid = b + tc;
			else if (sub < 94)
				pid = b + MAP_ENTRIES + 1;
			else if (full_ok)
				pid = b + MAP_ENTRIES;
		end else if (roll < 77) begin
			op = pum_pkg::OP_FIND;
		end else if (roll < 90) begin
			op = pum_pkg::OP_OWNER;
			// land on and next to group boundaries
			if (sub < 60)
				pid = longint'($urandom_range(32'(LAST_GROUP))) * GROUP + $urandom_range(2);
		end else if (roll < 94) begin
			op = 3'($urandom_range(OP_FIRST_RSVD, OP_LAST_RSVD));
		end else begin
			op = 3'($urandom_range(OP_LAST_RSVD));
			nf = 1'($urandom_range(1));
		end
		push_req(op, pid, nf);
	endtask

	task automatic run_random(input int n, input bit full_ok, input int avail_pct);
		repeat (n) add_random_req(full_ok, avail_pct);
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass on the reset base
		push_req(pum_pkg::OP_FIND, 0, 1'b0);
		push_req(pum_pkg::OP_QUERY, base_page_m + 1, 1'b0);
		push_req(pum_pkg::OP_EXTEND, base_page_m, 1'b0);
		push_req(pum_pkg::OP_EXTEND, base_page_m + MAP_ENTRIES + 1, 1'b0);
		push_req(pum_pkg::OP_EXTEND, base_page_m + 3, 1'b0);
		push_req(pum_pkg::OP_EXTEND, base_page_m + 3, 1'b0);
		push_req(pum_pkg::OP_SET, base_page_m + 3, 1'b1);
		push_req(pum_pkg::OP_QUERY, base_page_m + 3, 1'b0);
		push_req(pum_pkg::OP_FIND, ID_MAX, 1'b1);
		push_req(pum_pkg::OP_SET, base_page_m + 1, 1'b1);
		push_req(pum_pkg::OP_FIND, 0, 1'b0);
		push_req(pum_pkg::OP_SET, base_page_m + 1, 1'b0);
		push_req(pum_pkg::OP_QUERY, base_page_m + 4, 1'b0);
		push_req(pum_pkg::OP_SET, base_page_m, 1'b1);
		push_req(pum_pkg::OP_OWNER, 0, 1'b0);
		push_req(pum_pkg::OP_OWNER, 1, 1'b0);
		push_req(pum_pkg::OP_OWNER, GROUP + 1, 1'b0);
		push_req(pum_pkg::OP_OWNER, GROUP, 1'b0);
		push_req(pum_pkg::OP_OWNER, GROUP + 2, 1'b0);
		push_req(pum_pkg::OP_OWNER, ID_MAX, 1'b1);
		push_req(OP_FIRST_RSVD, ID_MAX, 1'b1);
		push_req(OP_FIRST_RSVD + 3'd1, GROUP, 1'b0);
		push_req(OP_LAST_RSVD, 0, 1'b1);
		push_req(pum_pkg::OP_SET, ID_MAX, 1'b1);
		push_req(pum_pkg::OP_QUERY, base_page_m + 1, 1'b0);
		drain();

		write_base(1);
		run_random(430, 1'b0, 50);
		// tracked pages now run past the top of the id space
		write_base(ID_MAX - 100);
		run_random(60, 1'b0, 50);
		write_base(ID_MAX);
		run_random(25, 1'b0, 50);

		sender_idle_pct = 67;
		receiver_idle_pct = 7;
		write_base(longint'($urandom_range(1, 32'(LAST_GROUP - 1))) * GROUP + 1);
		run_random(420, 1'b0, 40);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_base($urandom_range(2, 32'(ID_MAX - MAP_ENTRIES)));
		run_random(400, 1'b1, 20);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0d expected results never arrived", results_due.size());
			fail_cnt += results_due.size();
		end
		$display("covered %0d transactions under %0d base settings in %0d cycles",
			reqs_pushed, base_settings, cycle_cnt);
		$display("finds that hit a page: %0d, extends taken: %0d, final tracked count %0d",
			finds_hit, extends_taken, tracked_pages);
		if (fail_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d failures", fail_cnt);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pum_pkg.sv
rtl/pum_front.sv
rtl/pum_fifo.sv
rtl/pum_back.sv
rtl/page_usage_map_unit.sv
tb/sv/tb_top.sv
